>>> hdl/pnmdec_pkg.sv
// Package for the PNM stream decoder: transfer types, codes and constants.
// Used by the front end, back end and top level of the decoder; depends on nothing else.
package pnmdec_pkg;

   // defaults for the dimension counter width and the queue depths
   localparam int DIM_BITS_DEF = 14;
   localparam int IN_DEPTH_DEF = 2;
   localparam int OUT_DEPTH_DEF = 2;

   // register map
   localparam int PADDR_BITS = 3;
   localparam logic REG_ALLOW_16BIT = 1'b0;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // status codes
   localparam logic ST_OK = 1'b0;
   localparam logic ST_FAIL = 1'b1;

   // parse phases
   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_MAGIC2 = 4'd1;
   localparam logic [3:0] PH_W_SKIP = 4'd2;
   localparam logic [3:0] PH_W_DIG = 4'd3;
   localparam logic [3:0] PH_H_SKIP = 4'd4;
   localparam logic [3:0] PH_H_DIG = 4'd5;
   localparam logic [3:0] PH_M_SKIP = 4'd6;
   localparam logic [3:0] PH_M_DIG = 4'd7;
   localparam logic [3:0] PH_S_SKIP = 4'd8;
   localparam logic [3:0] PH_S_DIG = 4'd9;
   localparam logic [3:0] PH_RAW = 4'd10;
   localparam logic [3:0] PH_DONE = 4'd11;

   // formats
   localparam logic [2:0] FMT_P1 = 3'd1;
   localparam logic [2:0] FMT_P2 = 3'd2;
   localparam logic [2:0] FMT_P4 = 3'd4;
   localparam logic [2:0] FMT_P5 = 3'd5;

   // characters
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_P = 8'h50;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_ONE = 8'h31;
   localparam logic [7:0] CH_SIX = 8'h36;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_LF = 8'h0a;

   localparam logic [16:0] ACC_SAT = 17'h1ffff;
   localparam logic [15:0] MAX_8BIT = 16'h00ff;
   localparam logic [15:0] MAX_16BIT = 16'hffff;

   typedef struct packed {
      logic       action;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [13:0] image_width;
      logic [13:0] image_height;
      logic        status;
      logic        last;
   } rsp_type;

   // classified input item between front and back
   typedef struct packed {
      logic       eos;
      logic [7:0] byte_value;
      logic       is_space;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_hash;
      logic       is_eol;
      logic       is_p;
      logic       is_magic;
      logic       is_zero;
      logic       is_one;
   } cls_type;

endpackage

>>> hdl/pnmdec_fifo.sv
// Small first-word-fall-through queue built from registers.
// Generic; no package dependency.
module pnmdec_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign full = (count_ff == (AW+1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_data = mem_ff[rptr_ff];

   // pointer and fill update
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == AW'(DEPTH-1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == AW'(DEPTH-1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

>>> hdl/pnmdec_front.sv
// Front end: accepts input transfers, classifies each byte, queues it.
// Depends on pnmdec_pkg and pnmdec_fifo.
module pnmdec_front
   import pnmdec_pkg::*;
#(
   parameter int DEPTH = IN_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   input  logic    q_pop,
   output logic    q_empty,
   output cls_type q_data
);
   cls_type cls;
   logic [7:0] c;

   // character classes
   always_comb begin
      c = req_data.byte_value;
      cls.eos = req_data.action;
      cls.byte_value = c;
      cls.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
      cls.is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      cls.digit = 4'(c - CH_ZERO);
      cls.is_hash = (c == CH_HASH);
      cls.is_eol = (c == CH_LF) || (c == CH_CR);
      cls.is_p = (c == CH_P);
      cls.is_magic = (c >= CH_ONE) && (c <= CH_SIX);
      cls.is_zero = (c == CH_ZERO);
      cls.is_one = (c == CH_ONE);
   end

   pnmdec_fifo #(
      .WIDTH($bits(cls_type)),
      .DEPTH(DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .wr_en(push),
      .wr_data(cls),
      .full(full),
      .rd_en(q_pop),
      .rd_data(q_data),
      .empty(q_empty)
   );

endmodule

>>> hdl/pnmdec_div.sv
// Sample scaler: floor((510*v + m) / (2*m)), one quotient bit a cycle.
// Depends on nothing; eight steps after start, quotient fits 8 bits as v <= m.
module pnmdec_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] value,
   input  logic [15:0] maxval,
   output logic        done,
   output logic [7:0]  quot
);
   logic [24:0] rem_ff, rem_in;
   logic [23:0] dsh_ff, dsh_in;
   logic [7:0] quot_ff, quot_in;
   logic [2:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic ge;

   assign ge = rem_ff >= {1'b0, dsh_ff};
   assign done = done_ff;
   assign quot = quot_ff;

   // restoring division step
   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quot_in = quot_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = ({value, 9'd0} - {8'd0, value, 1'b0}) + {9'd0, maxval};
         dsh_in = {maxval, 8'd0};
         quot_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - {1'b0, dsh_ff};
         end
         quot_in = {quot_ff[6:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quot_ff <= quot_in;
   end

endmodule

>>> hdl/pnmdec_back.sv
// Back end: parse engine that turns classified bytes into result transfers.
// Depends on pnmdec_pkg and pnmdec_div; each byte is handled to the end before another is fetched.
module pnmdec_back
   import pnmdec_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    allow_16bit,
   input  logic    q_empty,
   input  cls_type q_data,
   output logic    q_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_res
);
   localparam logic [16:0] DIM_MAX = 17'((1 << DIM_BITS) - 1);

   localparam logic [2:0] B_FETCH = 3'd0;
   localparam logic [2:0] B_EXEC = 3'd1;
   localparam logic [2:0] B_SAMP = 3'd2;
   localparam logic [2:0] B_DIV = 3'd3;
   localparam logic [2:0] B_COMP = 3'd4;
   localparam logic [2:0] B_PIX = 3'd5;
   localparam logic [2:0] B_STAT = 3'd6;
   localparam logic [2:0] B_TAIL = 3'd7;

   logic [2:0] bstate_ff, bstate_in;
   cls_type item_ff, item_in;
   logic [3:0] phase_ff, phase_in;
   logic [2:0] fmt_ff, fmt_in;
   logic [DIM_BITS-1:0] width_ff, width_in, height_ff, height_in;
   logic [DIM_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [DIM_BITS-1:0] col_nx, row_nx;
   logic [15:0] maxval_ff, maxval_in;
   logic [16:0] acc_ff, acc_in;
   logic comment_ff, comment_in;
   logic [1:0] comp_ff, comp_in;
   logic [7:0] red_ff, red_in, green_ff, green_in;
   logic [8:0] hb_ff, hb_in;
   logic [16:0] samp_ff, samp_in;
   logic [7:0] s_ff, s_in;
   logic [7:0] pr_ff, pr_in, pg_ff, pg_in, pb_ff, pb_in;
   logic bits_ff, bits_in;
   logic [2:0] bit_ff, bit_in;
   logic stat_ff, stat_in;
   logic [20:0] acc_mul;
   logic [15:0] lim;
   logic bad_dim, row_end, frame_end, more, clear_now;
   logic div_start, div_done;
   logic [7:0] div_quot, pix;

   pnmdec_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .value(samp_ff[15:0]),
      .maxval(maxval_ff),
      .done(div_done),
      .quot(div_quot)
   );

   // helpers for numbers and counters
   assign acc_mul = {1'b0, acc_ff, 3'd0} + {3'd0, acc_ff, 1'b0} + {17'd0, item_ff.digit};
   assign lim = allow_16bit ? MAX_16BIT : MAX_8BIT;
   assign bad_dim = (acc_ff == '0) || (acc_ff > DIM_MAX);
   assign col_nx = col_ff + 1'b1;
   assign row_nx = row_ff + 1'b1;
   assign row_end = (col_nx >= width_ff);
   assign frame_end = row_end && (row_nx >= height_ff);
   assign more = bits_ff && !row_end && (bit_ff != 3'd0);
   assign pix = item_ff.byte_value[bit_ff] ? 8'h00 : 8'hff;

   // engine
   always_comb begin
      bstate_in = bstate_ff;
      item_in = item_ff;
      phase_in = phase_ff;
      fmt_in = fmt_ff;
      width_in = width_ff;
      height_in = height_ff;
      col_in = col_ff;
      row_in = row_ff;
      maxval_in = maxval_ff;
      acc_in = acc_ff;
      comment_in = comment_ff;
      comp_in = comp_ff;
      red_in = red_ff;
      green_in = green_ff;
      hb_in = hb_ff;
      samp_in = samp_ff;
      s_in = s_ff;
      pr_in = pr_ff;
      pg_in = pg_ff;
      pb_in = pb_ff;
      bits_in = bits_ff;
      bit_in = bit_ff;
      stat_in = stat_ff;
      q_pop = 1'b0;
      rsp_push = 1'b0;
      rsp_res = '0;
      div_start = 1'b0;
      clear_now = 1'b0;
      case (bstate_ff)
         B_FETCH: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               item_in = q_data;
               bstate_in = B_EXEC;
            end
         end
         B_EXEC: begin
            if (!rsp_full) begin
               bstate_in = B_FETCH;
               if (item_ff.eos) begin
                  // end of stream: close a pending sample number first
                  if (phase_ff == PH_S_DIG) begin
                     phase_in = PH_S_SKIP;
                     acc_in = '0;
                     samp_in = acc_ff;
                     bstate_in = B_SAMP;
                  end else begin
                     bstate_in = B_TAIL;
                  end
               end else if (phase_ff == PH_IDLE) begin
                  if (item_ff.is_p) begin
                     phase_in = PH_MAGIC2;
                  end else begin
                     stat_in = ST_FAIL;
                     bstate_in = B_STAT;
                  end
               end else if (phase_ff == PH_MAGIC2) begin
                  if (item_ff.is_magic) begin
                     fmt_in = item_ff.digit[2:0];
                     phase_in = PH_W_SKIP;
                  end else begin
                     stat_in = ST_FAIL;
                     bstate_in = B_STAT;
                  end
               end else if (phase_ff == PH_W_SKIP || phase_ff == PH_H_SKIP ||
                            phase_ff == PH_M_SKIP || phase_ff == PH_S_SKIP) begin
                  // whitespace, comments and the start of a number
                  if (comment_ff) begin
                     if (item_ff.is_eol) begin
                        comment_in = 1'b0;
                     end
                  end else if (item_ff.is_space) begin
                     comment_in = comment_ff;
                  end else if (item_ff.is_hash) begin
                     comment_in = 1'b1;
                  end else if (phase_ff == PH_S_SKIP && fmt_ff == FMT_P1) begin
                     if (item_ff.is_zero || item_ff.is_one) begin
                        pr_in = item_ff.is_zero ? 8'hff : 8'h00;
                        pg_in = item_ff.is_zero ? 8'hff : 8'h00;
                        pb_in = item_ff.is_zero ? 8'hff : 8'h00;
                        bits_in = 1'b0;
                        bstate_in = B_PIX;
                     end else begin
                        stat_in = ST_FAIL;
                        bstate_in = B_STAT;
                     end
                  end else if (item_ff.is_digit) begin
                     acc_in = {13'd0, item_ff.digit};
                     phase_in = phase_ff + 4'd1;
                  end else begin
                     stat_in = ST_FAIL;
                     bstate_in = B_STAT;
                  end
               end else if (phase_ff == PH_W_DIG || phase_ff == PH_H_DIG ||
                            phase_ff == PH_M_DIG || phase_ff == PH_S_DIG) begin
                  if (item_ff.is_digit) begin
                     acc_in = (acc_mul > {4'd0, ACC_SAT}) ? ACC_SAT : acc_mul[16:0];
                  end else begin
                     // terminator: the number is complete
                     acc_in = '0;
                     if (phase_ff == PH_W_DIG) begin
                        if (bad_dim) begin
                           stat_in = ST_FAIL;
                           bstate_in = B_STAT;
                        end else begin
                           width_in = acc_ff[DIM_BITS-1:0];
                           phase_in = PH_H_SKIP;
                        end
                     end else if (phase_ff == PH_H_DIG) begin
                        if (bad_dim) begin
                           stat_in = ST_FAIL;
                           bstate_in = B_STAT;
                        end else begin
                           height_in = acc_ff[DIM_BITS-1:0];
                           rsp_push = 1'b1;
                           rsp_res.kind = KIND_HEADER;
                           rsp_res.image_width = 14'(width_ff);
                           rsp_res.image_height = 14'(acc_ff[DIM_BITS-1:0]);
                           rsp_res.last = 1'b1;
                           if (fmt_ff == FMT_P1) begin
                              phase_in = PH_S_SKIP;
                           end else if (fmt_ff == FMT_P4) begin
                              phase_in = PH_RAW;
                           end else begin
                              phase_in = PH_M_SKIP;
                           end
                        end
                     end else if (phase_ff == PH_M_DIG) begin
                        if (acc_ff == '0 || acc_ff > {1'b0, lim}) begin
                           stat_in = ST_FAIL;
                           bstate_in = B_STAT;
                        end else begin
                           maxval_in = acc_ff[15:0];
                           phase_in = (fmt_ff >= FMT_P5) ? PH_RAW : PH_S_SKIP;
                        end
                     end else begin
                        phase_in = PH_S_SKIP;
                        samp_in = acc_ff;
                        bstate_in = B_SAMP;
                     end
                  end
               end else if (phase_ff == PH_RAW) begin
                  // raw data bytes
                  if (fmt_ff == FMT_P4) begin
                     bits_in = 1'b1;
                     bit_in = 3'd7;
                     bstate_in = B_PIX;
                  end else if (maxval_ff > MAX_8BIT) begin
                     if (hb_ff[8]) begin
                        samp_in = {1'b0, hb_ff[7:0], item_ff.byte_value};
                        hb_in = '0;
                        bstate_in = B_SAMP;
                     end else begin
                        hb_in = {1'b1, item_ff.byte_value};
                     end
                  end else begin
                     samp_in = {9'd0, item_ff.byte_value};
                     bstate_in = B_SAMP;
                  end
               end
            end
         end
         B_SAMP: begin
            // range check, then scale unless maxval is 255 or 0
            if (samp_ff > {1'b0, maxval_ff}) begin
               stat_in = ST_FAIL;
               bstate_in = B_STAT;
            end else if (maxval_ff == MAX_8BIT || maxval_ff == '0) begin
               s_in = samp_ff[7:0];
               bstate_in = B_COMP;
            end else begin
               div_start = 1'b1;
               bstate_in = B_DIV;
            end
         end
         B_DIV: begin
            if (div_done) begin
               s_in = div_quot;
               bstate_in = B_COMP;
            end
         end
         B_COMP: begin
            // grey goes out at once, colour gathers three components
            bits_in = 1'b0;
            if (fmt_ff == FMT_P2 || fmt_ff == FMT_P5) begin
               pr_in = s_ff;
               pg_in = s_ff;
               pb_in = s_ff;
               bstate_in = B_PIX;
            end else if (comp_ff == 2'd0) begin
               red_in = s_ff;
               comp_in = 2'd1;
               bstate_in = B_TAIL;
            end else if (comp_ff == 2'd1) begin
               green_in = s_ff;
               comp_in = 2'd2;
               bstate_in = B_TAIL;
            end else begin
               comp_in = 2'd0;
               pr_in = red_ff;
               pg_in = green_ff;
               pb_in = s_ff;
               bstate_in = B_PIX;
            end
         end
         B_PIX: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               rsp_res.kind = KIND_PIXEL;
               rsp_res.red = bits_ff ? pix : pr_ff;
               rsp_res.green = bits_ff ? pix : pg_ff;
               rsp_res.blue = bits_ff ? pix : pb_ff;
               rsp_res.last = !frame_end && !more && !item_ff.eos;
               col_in = row_end ? '0 : col_nx;
               if (row_end) begin
                  row_in = row_nx;
               end
               if (frame_end) begin
                  stat_in = ST_OK;
                  bstate_in = B_STAT;
               end else if (more) begin
                  bit_in = bit_ff - 1'b1;
               end else begin
                  bstate_in = B_TAIL;
               end
            end
         end
         B_STAT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               rsp_res.kind = KIND_STATUS;
               rsp_res.status = stat_ff;
               rsp_res.last = 1'b1;
               phase_in = PH_DONE;
               clear_now = item_ff.eos;
               bstate_in = B_FETCH;
            end
         end
         B_TAIL: begin
            // end of stream without a status yet reports failure
            if (item_ff.eos && phase_ff != PH_DONE) begin
               stat_in = ST_FAIL;
               bstate_in = B_STAT;
            end else begin
               clear_now = item_ff.eos;
               bstate_in = B_FETCH;
            end
         end
         default: begin
            bstate_in = B_FETCH;
         end
      endcase
      // end of stream returns the parse state to reset
      if (clear_now) begin
         phase_in = PH_IDLE;
         fmt_in = '0;
         width_in = '0;
         height_in = '0;
         maxval_in = '0;
         acc_in = '0;
         comment_in = 1'b0;
         col_in = '0;
         row_in = '0;
         comp_in = '0;
         red_in = '0;
         green_in = '0;
         hb_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff <= B_FETCH;
         phase_ff <= PH_IDLE;
         fmt_ff <= '0;
         width_ff <= '0;
         height_ff <= '0;
         maxval_ff <= '0;
         acc_ff <= '0;
         comment_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
         comp_ff <= '0;
         red_ff <= '0;
         green_ff <= '0;
         hb_ff <= '0;
      end else begin
         bstate_ff <= bstate_in;
         phase_ff <= phase_in;
         fmt_ff <= fmt_in;
         width_ff <= width_in;
         height_ff <= height_in;
         maxval_ff <= maxval_in;
         acc_ff <= acc_in;
         comment_ff <= comment_in;
         col_ff <= col_in;
         row_ff <= row_in;
         comp_ff <= comp_in;
         red_ff <= red_in;
         green_ff <= green_in;
         hb_ff <= hb_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      samp_ff <= samp_in;
      s_ff <= s_in;
      pr_ff <= pr_in;
      pg_ff <= pg_in;
      pb_ff <= pb_in;
      bits_ff <= bits_in;
      bit_ff <= bit_in;
      stat_ff <= stat_in;
   end

endmodule

>>> hdl/pnm_image_stream_decoder_core.sv
// Top level of the PNM (P1..P6) stream decoder: ports, register and queues.
// Depends on pnmdec_pkg, pnmdec_front, pnmdec_back and pnmdec_fifo.

// Feed the file one byte per transfer, then one end-of-stream transfer; results come
// out as a header, one result per pixel in raster order and a final status, with last
// set on the final result of each input. A single parse engine produces at most one
// result per cycle and finishes each byte before it fetches another. A sample is range
// checked and, unless maxval is 255, scaled by the bit-serial scaler; a raw bitmap
// byte gives one pixel per bit up to the end of a row. A status is sent from its own
// state, and a full result queue stalls the engine. A short input queue keeps
// accepting bytes while the engine works. allow_16bit sits at byte address 0; the user
// must write it only while the block is idle; the block does not enforce this.
module pnm_image_stream_decoder_core
   import pnmdec_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_data,
   output logic                  empty,
   input  logic                  pop,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   logic allow_ff, allow_in;
   logic reg_hit;
   logic q_pop, q_empty;
   cls_type q_data;
   logic rsp_full, rsp_push;
   rsp_type rsp_res;

   // configuration register
   assign pready = 1'b1;
   assign reg_hit = (paddr[PADDR_BITS-1:2] == REG_ALLOW_16BIT);
   assign allow_in = (psel && penable && pwrite && reg_hit) ? pwdata[0] : allow_ff;
   assign prdata = reg_hit ? {31'd0, allow_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ff <= 1'b0;
      end else begin
         allow_ff <= allow_in;
      end
   end

   pnmdec_front #(
      .DEPTH(IN_DEPTH_DEF)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .q_pop(q_pop),
      .q_empty(q_empty),
      .q_data(q_data)
   );

   pnmdec_back #(
      .DIM_BITS(DIM_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .allow_16bit(allow_ff),
      .q_empty(q_empty),
      .q_data(q_data),
      .q_pop(q_pop),
      .rsp_full(rsp_full),
      .rsp_push(rsp_push),
      .rsp_res(rsp_res)
   );

   // result queue
   pnmdec_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(OUT_DEPTH_DEF)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .wr_en(rsp_push),
      .wr_data(rsp_res),
      .full(rsp_full),
      .rd_en(pop),
      .rd_data(rsp_data),
      .empty(empty)
   );

`ifndef SYNTH
   // engine never writes into a full result queue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result written while queue full");

   // a status closes the results of its input
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.kind == KIND_STATUS) |-> rsp_data.last)
      else $error("status without last");

   // only pixels carry colour
   a_colour_pixel: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.kind != KIND_PIXEL) |->
      (rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0))
      else $error("colour on non-pixel result");
`endif

endmodule

>>> verif/pnm_decoder_checker.sv
// Checker for the PNM stream decoder: watches the byte, result and register ports.
// Predicts the results of each byte transfer and compares them in order; uses pnmdec_pkg.
`timescale 1ns / 100ps

module pnm_decoder_checker
   import pnmdec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  req_type               req_data,
   input  logic                  empty,
   input  logic                  pop,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [31:0]           pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    pending,
   output int                    checked
);

   localparam int DIM_MAX = 16383;

   // decoder copy: register and parse state
   logic        wide_ok;
   logic [3:0]  phase;
   logic [2:0]  fmt;
   int          img_w, img_h, maxv, accum, col, row;
   logic        comment_on;
   int          comp_idx, red_keep, green_keep, hi_byte;

   rsp_type     step_res[$];
   rsp_type     pixel_due[$];

   assign pending = pixel_due.size();

   function automatic bit is_ws(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic bit is_num(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   task automatic add_res(logic [1:0] k, int r, int g, int b, int w, int h, logic st);
      rsp_type x;
      x.kind = k;
      x.red = r[7:0];
      x.green = g[7:0];
      x.blue = b[7:0];
      x.image_width = w[13:0];
      x.image_height = h[13:0];
      x.status = st;
      x.last = 1'b0;
      step_res.push_back(x);
   endtask

   task automatic end_file(logic st);
      add_res(KIND_STATUS, 0, 0, 0, 0, 0, st);
      phase = PH_DONE;
   endtask

   task automatic put_pixel(int r, int g, int b);
      add_res(KIND_PIXEL, r, g, b, 0, 0, ST_OK);
      col = (col + 1) & DIM_MAX;
      if (col >= img_w) begin
         col = 0;
         row = (row + 1) & DIM_MAX;
         if (row >= img_h) end_file(ST_OK);
      end
   endtask

   task automatic take_sample(int v);
      int s;
      if (v > maxv) begin
         end_file(ST_FAIL);
         return;
      end
      if (maxv == 255 || maxv == 0) s = v & 255;
      else s = (510 * v + maxv) / (2 * maxv);
      if (fmt == FMT_P2 || fmt == FMT_P5) put_pixel(s, s, s);
      else if (comp_idx == 0) begin
         red_keep = s;
         comp_idx = 1;
      end else if (comp_idx == 1) begin
         green_keep = s;
         comp_idx = 2;
      end else begin
         comp_idx = 0;
         put_pixel(red_keep, green_keep, s);
      end
   endtask

   task automatic number_end();
      int v;
      int lim;
      v = accum;
      lim = wide_ok ? 65535 : 255;
      accum = 0;
      if (phase == PH_W_DIG) begin
         if (v == 0 || v > DIM_MAX) end_file(ST_FAIL);
         else begin
            img_w = v;
            phase = PH_H_SKIP;
         end
      end else if (phase == PH_H_DIG) begin
         if (v == 0 || v > DIM_MAX) end_file(ST_FAIL);
         else begin
            img_h = v;
            add_res(KIND_HEADER, 0, 0, 0, img_w, img_h, ST_OK);
            if (fmt == FMT_P1) phase = PH_S_SKIP;
            else if (fmt == FMT_P4) phase = PH_RAW;
            else phase = PH_M_SKIP;
         end
      end else if (phase == PH_M_DIG) begin
         if (v == 0 || v > lim) end_file(ST_FAIL);
         else begin
            maxv = v;
            phase = (fmt >= FMT_P5) ? PH_RAW : PH_S_SKIP;
         end
      end else begin
         phase = PH_S_SKIP;
         take_sample(v);
      end
   endtask

   task automatic raw_in(logic [7:0] c);
      int v;
      if (fmt == FMT_P4) begin
         for (int s = 7; s >= 0 && phase == PH_RAW; s--) begin
            v = c[s] ? 0 : 255;
            put_pixel(v, v, v);
            if (col == 0) break;
         end
      end else if (maxv > 255) begin
         if (hi_byte[8]) begin
            v = ((hi_byte & 255) << 8) | c;
            hi_byte = 0;
            take_sample(v);
         end else hi_byte = 256 | c;
      end else take_sample(c);
   endtask

   task automatic clear_file();
      phase = PH_IDLE;
      fmt = '0;
      img_w = 0; img_h = 0; maxv = 0; accum = 0; col = 0; row = 0;
      comment_on = 1'b0;
      comp_idx = 0; red_keep = 0; green_keep = 0; hi_byte = 0;
   endtask

   // works out the results of one byte transfer and queues them
   task automatic decode_byte(req_type t);
      logic [7:0] c;
      int a;
      c = t.byte_value;
      step_res.delete();
      if (t.action) begin
         if (phase == PH_S_DIG) number_end();
         if (phase != PH_DONE) end_file(ST_FAIL);
         clear_file();
      end else if (phase == PH_IDLE) begin
         if (c == CH_P) phase = PH_MAGIC2;
         else end_file(ST_FAIL);
      end else if (phase == PH_MAGIC2) begin
         if (c >= CH_ONE && c <= CH_SIX) begin
            fmt = 3'(c - CH_ZERO);
            phase = PH_W_SKIP;
         end else end_file(ST_FAIL);
      end else if (phase == PH_W_SKIP || phase == PH_H_SKIP ||
                   phase == PH_M_SKIP || phase == PH_S_SKIP) begin
         if (comment_on) begin
            if (c == CH_LF || c == CH_CR) comment_on = 1'b0;
         end else if (is_ws(c)) begin
         end else if (c == CH_HASH) begin
            comment_on = 1'b1;
         end else if (phase == PH_S_SKIP && fmt == FMT_P1) begin
            if (c == CH_ZERO) put_pixel(255, 255, 255);
            else if (c == CH_ONE) put_pixel(0, 0, 0);
            else end_file(ST_FAIL);
         end else if (is_num(c)) begin
            accum = c - CH_ZERO;
            phase = phase + 4'd1;
         end else end_file(ST_FAIL);
      end else if (phase == PH_W_DIG || phase == PH_H_DIG ||
                   phase == PH_M_DIG || phase == PH_S_DIG) begin
         if (is_num(c)) begin
            a = accum * 10 + (c - CH_ZERO);
            accum = (a > int'(ACC_SAT)) ? int'(ACC_SAT) : a;
         end else number_end();
      end else if (phase == PH_RAW) begin
         raw_in(c);
      end
      if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
      foreach (step_res[i]) pixel_due.push_back(step_res[i]);
   endtask

   task automatic field_check(string name, int want, int got);
      if (want != got) begin
         $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // observe all three ports at each edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         wide_ok = 1'b0;
         clear_file();
         pixel_due.delete();
         fail_count = 0;
         checked = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == (PADDR_BITS'(REG_ALLOW_16BIT) << 2))
            wide_ok = pwdata[0];
         if (push && !full) decode_byte(req_data);
         if (pop && !empty) begin
            if (pixel_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = pixel_due.pop_front();
               field_check("kind", want.kind, rsp_data.kind);
               field_check("red", want.red, rsp_data.red);
               field_check("green", want.green, rsp_data.green);
               field_check("blue", want.blue, rsp_data.blue);
               field_check("image_width", want.image_width, rsp_data.image_width);
               field_check("image_height", want.image_height, rsp_data.image_height);
               field_check("status", want.status, rsp_data.status);
               field_check("last", want.last, rsp_data.last);
               checked++;
            end
         end
      end
   end

endmodule

>>> verif/tb_pnm_image_stream_decoder_core.sv
// Testbench top for the PNM stream decoder: clock, reset, file stimulus and verdict.
// Depends on pnmdec_pkg, the decoder core and pnm_decoder_checker.
`timescale 1ns / 100ps

module tb_pnm_image_stream_decoder_core;
   import pnmdec_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  push, full, empty, pop;
   req_type               req_data;
   rsp_type               rsp_data;
   logic                  psel, penable, pwrite, pready;
   logic [PADDR_BITS-1:0] paddr;
   logic [31:0]           pwdata, prdata;
   int                    fail_count, pending, checked;

   logic [7:0] file_q[$];
   bit         wide_mode;
   bit         hold_rsp;
   int         bytes_sent, files_sent;

   pnm_image_stream_decoder_core dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pnm_decoder_checker chk (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // run limit
   initial begin
      #4ms;
      $display("TEST FAILED");
      $finish;
   end

   // result side: varying pop rate, plus a long hold-off on request
   initial begin
      int pct;
      int left;
      pop = 1'b0;
      pct = 100;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            pop <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (left == 0) begin
               case ($urandom_range(0, 3))
                  0: pct = 100;
                  1: pct = 70;
                  2: pct = 25;
                  default: pct = 0;
               endcase
               left = (pct == 0) ? $urandom_range(10, 60) : $urandom_range(20, 120);
            end
            left--;
            pop <= ($urandom_range(0, 99) < pct);
         end
      end
   end

   // one byte transfer, holding push across back-to-back items
   task automatic send_item(logic act, logic [7:0] b);
      int r;
      int gap;
      r = $urandom_range(0, 99);
      gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0 && push) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= '{action: act, byte_value: b};
      forever begin
         @(negedge clock);
         if (!full) break;
         @(posedge clock);
      end
      @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_q[i]) send_item(1'b0, file_q[i]);
      send_item(1'b1, 8'($urandom));
      file_q.delete();
      files_sent++;
   endtask

   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (40) @(posedge clock);
   endtask

   // register write, only while the block is idle
   task automatic set_wide(bit v);
      drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PADDR_BITS'(REG_ALLOW_16BIT) << 2;
      pwdata <= ($urandom & 32'hffff_fffe) | 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      wide_mode = v;
   endtask

   task automatic add_str(string s);
      foreach (s[i]) file_q.push_back(s[i]);
   endtask

   task automatic add_num(int v);
      add_str($sformatf("%0d", v));
   endtask

   task automatic add_sep();
      case ($urandom_range(0, 9))
         0: add_str("\t");
         1: add_str("\n");
         2: add_str("\r");
         3: add_str("\013\014 ");
         4: add_str(" # note\n");
         5: add_str("#\r ");
         default: add_str(" ");
      endcase
   endtask

   task automatic send_str(string s);
      add_str(s);
      send_file();
   endtask

   // random file, mostly well formed with random content
   task automatic random_file();
      int fmt, w, h, mv, r, v, npix;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
         send_file();
         return;
      end
      fmt = $urandom_range(1, 6);
      w = $urandom_range(1, 3);
      h = $urandom_range(1, 3);
      if (r < 10) w = ($urandom_range(0, 1)) ? 0 : 16384;
      if (r >= 10 && r < 12) h = 99999999;
      // oversized images fail at the header, so they carry a token payload
      npix = (w > 3 || h > 3) ? 1 : w * h;
      mv = 255;
      case ($urandom_range(0, 5))
         0: mv = 1;
         1: mv = $urandom_range(2, 254);
         2: mv = wide_mode ? $urandom_range(256, 65535) : $urandom_range(2, 255);
         3: mv = wide_mode ? 65535 : 255;
         4: mv = (r < 15) ? 256 : 255;
         default: mv = 255;
      endcase
      add_str($sformatf("P%0d", fmt));
      add_sep();
      add_num(w);
      add_sep();
      add_num(h);
      if (fmt != 1 && fmt != 4) begin
         add_sep();
         add_num(mv);
      end
      if (fmt >= 4) add_str("\n");
      else add_sep();
      if (fmt == 1) begin
         repeat (npix) begin
            add_str($urandom_range(0, 1) ? "1" : "0");
            if ($urandom_range(0, 2) == 0) add_sep();
         end
      end else if (fmt == 4) begin
         repeat ((w > 3 || h > 3) ? 1 : h * ((w + 7) / 8)) file_q.push_back(8'($urandom));
      end else begin
         repeat (npix * ((fmt == 3 || fmt == 6) ? 3 : 1)) begin
            v = ($urandom_range(0, 19) == 0) ? mv + 1 : $urandom_range(0, mv);
            if (fmt <= 3) begin
               add_num(v);
               add_sep();
            end else if (mv > 255) begin
               file_q.push_back(8'(v >> 8));
               file_q.push_back(8'(v));
            end else file_q.push_back(8'(v));
         end
      end
      // some files are cut short or carry trailing bytes
      if (r >= 90 && file_q.size() > 4) file_q = file_q[0:$urandom_range(2, file_q.size() - 2)];
      if (r >= 85 && r < 90) add_str("junk");
      send_file();
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      hold_rsp = 1'b0;
      wide_mode = 1'b0;
      bytes_sent = 0;
      files_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: formats, limits and failure paths, first ones against a stalled output
      set_wide(1'b0);
      hold_rsp = 1'b1;
      send_str("P1\n2 2\n0110");
      send_str("P2 # c\n2 1 255\n0 255 ");
      send_str("P3 1 1 7 7 0 3");
      add_str("P4 9 2\n");
      file_q.push_back(8'ha5); file_q.push_back(8'h80);
      file_q.push_back(8'hff); file_q.push_back(8'h00);
      send_file();
      send_str("");
      send_str("Q1");
      send_str("P2 16384 1 5");
      send_str("P2 1 1 256");
      send_str("P2 1 1 3 4");
      send_str("P1 1 1 2");
      send_str("P2 1#1 5 3");

      // 16-bit samples, then random files
      set_wide(1'b1);
      add_str("P6 1 1 65535\n");
      repeat (6) file_q.push_back(8'($urandom));
      send_file();
      add_str("P5 2 1 300\n");
      file_q.push_back(8'h01); file_q.push_back(8'h2c); file_q.push_back(8'h00);
      send_file();
      while (bytes_sent < 170) random_file();

      drain();
      $display("Sent %0d byte transfers in %0d files; %0d results checked.",
               bytes_sent, files_sent, checked);
      $display("Covered P1..P6, comments, 16-bit samples and the failure paths.");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> pnm_image_stream_decoder_core.f
hdl/pnmdec_pkg.sv
hdl/pnmdec_fifo.sv
hdl/pnmdec_front.sv
hdl/pnmdec_div.sv
hdl/pnmdec_back.sv
hdl/pnm_image_stream_decoder_core.sv
verif/pnm_decoder_checker.sv
verif/tb_pnm_image_stream_decoder_core.sv
